/* hdl/spld_pkg.sv */
`default_nettype none

package spld_pkg;

  localparam int unsigned SAMPLE_BITS = 24;
  localparam int unsigned COEFF_BITS  = 24;
  localparam int unsigned GUARD_BITS  = 8;
  localparam int unsigned STATE_BITS  = SAMPLE_BITS + GUARD_BITS;
  localparam int unsigned DIFF_BITS   = STATE_BITS + 1;
  localparam int unsigned PROD_BITS   = DIFF_BITS + COEFF_BITS;
  localparam int unsigned QUOT_BITS   = PROD_BITS + 1 - COEFF_BITS;
  localparam int unsigned DATA_BITS   = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int unsigned CFG_BITS    = COEFF_BITS;
  localparam int unsigned CFG_IDX_BITS = 2;

  localparam logic [COEFF_BITS-1:0] ATTACK_RESET  = COEFF_BITS'(16742300);
  localparam logic [COEFF_BITS-1:0] RELEASE_RESET = COEFF_BITS'(16773726);

  localparam logic [CFG_IDX_BITS-1:0] CFG_ATTACK  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RELEASE = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MODE    = 2'd2;

  localparam int unsigned PC_BITS = 4;
  localparam logic [PC_BITS-1:0] PC_WAIT   = 4'd0;
  localparam logic [PC_BITS-1:0] PC_BR     = 4'd1;
  localparam logic [PC_BITS-1:0] PC_DEC    = 4'd4;
  localparam logic [PC_BITS-1:0] PC_EMIT   = 4'd10;
  localparam logic [PC_BITS-1:0] PC_LAST   = PC_EMIT;

  typedef enum logic [2:0] {OP_WAIT, OP_LOAD, OP_MUL, OP_ACC, OP_EMIT} op_e;
  typedef enum logic {SRC_SMOOTH, SRC_PEAK} src_e;
  typedef enum logic {INP_SAMPLE, INP_PEAK} inp_e;
  typedef enum logic [1:0] {COEF_BRANCH, COEF_ATTACK, COEF_RELEASE} coef_e;
  typedef enum logic {DST_SMOOTH, DST_PEAK} dst_e;
  typedef enum logic [1:0] {JC_NEXT, JC_GOTO, JC_BEAT, JC_OUTFREE} jc_e;

  typedef struct packed {
    op_e              op;
    src_e             src;
    inp_e             inp;
    coef_e            coef;
    dst_e             dst;
    jc_e              jc;
    logic [PC_BITS-1:0] target;
  } uword_t;

  function automatic uword_t uw(op_e op, src_e src, inp_e inp, coef_e coef, dst_e dst,
                                jc_e jc, logic [PC_BITS-1:0] target);
    uword_t w;
    w.op     = op;
    w.src    = src;
    w.inp    = inp;
    w.coef   = coef;
    w.dst    = dst;
    w.jc     = jc;
    w.target = target;
    return w;
  endfunction

  // branched: 1..3, decoupled: 4..9 (release peak hold, then attack smoother)
  function automatic uword_t ucode(logic [PC_BITS-1:0] pc);
    uword_t w;
    unique case (pc)
      4'd0:    w = uw(OP_WAIT, SRC_SMOOTH, INP_SAMPLE, COEF_BRANCH, DST_SMOOTH, JC_BEAT, PC_DEC);
      4'd1:    w = uw(OP_LOAD, SRC_SMOOTH, INP_SAMPLE, COEF_BRANCH, DST_SMOOTH, JC_NEXT, PC_WAIT);
      4'd2:    w = uw(OP_MUL, SRC_SMOOTH, INP_SAMPLE, COEF_BRANCH, DST_SMOOTH, JC_NEXT, PC_WAIT);
      4'd3:    w = uw(OP_ACC, SRC_SMOOTH, INP_SAMPLE, COEF_BRANCH, DST_SMOOTH, JC_GOTO, PC_EMIT);
      4'd4:    w = uw(OP_LOAD, SRC_PEAK, INP_SAMPLE, COEF_RELEASE, DST_PEAK, JC_NEXT, PC_WAIT);
      4'd5:    w = uw(OP_MUL, SRC_PEAK, INP_SAMPLE, COEF_RELEASE, DST_PEAK, JC_NEXT, PC_WAIT);
      4'd6:    w = uw(OP_ACC, SRC_PEAK, INP_SAMPLE, COEF_RELEASE, DST_PEAK, JC_NEXT, PC_WAIT);
      4'd7:    w = uw(OP_LOAD, SRC_SMOOTH, INP_PEAK, COEF_ATTACK, DST_SMOOTH, JC_NEXT, PC_WAIT);
      4'd8:    w = uw(OP_MUL, SRC_SMOOTH, INP_PEAK, COEF_ATTACK, DST_SMOOTH, JC_NEXT, PC_WAIT);
      4'd9:    w = uw(OP_ACC, SRC_SMOOTH, INP_PEAK, COEF_ATTACK, DST_SMOOTH, JC_NEXT, PC_WAIT);
      4'd10:   w = uw(OP_EMIT, SRC_SMOOTH, INP_SAMPLE, COEF_BRANCH, DST_SMOOTH, JC_OUTFREE,
                      PC_WAIT);
      default: w = uw(OP_WAIT, SRC_SMOOTH, INP_SAMPLE, COEF_BRANCH, DST_SMOOTH, JC_GOTO,
                      PC_WAIT);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* hdl/smooth_peak_level_detector_unit.sv */
`default_nettype none

// Channel   Direction  Handshake                    Payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tdata[23:0] = sample
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata[23:0] = level
// cfg       in         cfg_we_i (no wait)           cfg_idx_i, cfg_data_i
//
// A sequencer runs one control word per cycle over a single shared multiplier.
// Branched mode runs one filter pass per beat; decoupled mode runs two.
// Each pass is a load, a multiply and an accumulate step through the one multiplier.
// Output register holds a finished level while the next beat is taken in.
// A stalled output holds the sequencer at its emit step only.
// Reset restores coefficients and mode to defaults and clears both states.

module smooth_peak_level_detector_unit (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire  [spld_pkg::DATA_BITS-1:0]         s_axis_tdata,   // [23:0] sample
  output logic                                   m_axis_tvalid,
  input  wire                                    m_axis_tready,
  output logic [spld_pkg::DATA_BITS-1:0]         m_axis_tdata,   // [23:0] level
  input  wire                                    cfg_we_i,
  input  wire  [spld_pkg::CFG_IDX_BITS-1:0]      cfg_idx_i,
  input  wire  [spld_pkg::CFG_BITS-1:0]          cfg_data_i
);

  localparam int unsigned SB = spld_pkg::SAMPLE_BITS;
  localparam int unsigned CB = spld_pkg::COEFF_BITS;
  localparam int unsigned GB = spld_pkg::GUARD_BITS;
  localparam int unsigned TB = spld_pkg::STATE_BITS;
  localparam int unsigned DB = spld_pkg::DIFF_BITS;
  localparam int unsigned PB = spld_pkg::PROD_BITS;
  localparam int unsigned QB = spld_pkg::QUOT_BITS;

  logic [CB-1:0] attack_q, release_q;
  logic          mode_q;

  logic [spld_pkg::PC_BITS-1:0] pc_q, pc_d;
  spld_pkg::uword_t             uw;

  logic signed [SB-1:0] sample_q;
  logic signed [TB-1:0] smooth_q, peak_q;
  logic signed [TB-1:0] xop_q;
  logic [DB-1:0]        mag_q;
  logic                 neg_q;
  logic [CB-1:0]        coef_q;
  logic [PB-1:0]        prod_q;
  logic                 out_valid_q;
  logic signed [SB-1:0] out_q;

  logic                 in_beat, out_free;
  logic signed [TB-1:0] xs, s_src, x_src;
  logic signed [DB-1:0] diff;
  logic [PB:0]          rnd;
  logic [QB-1:0]        quot;
  logic [QB-1:0]        acc;
  logic signed [TB-1:0] res;
  logic signed [TB:0]   lvl_sum;
  logic signed [SB:0]   lvl_sh;
  logic signed [SB-1:0] lvl;

  assign uw            = spld_pkg::ucode(pc_q);
  assign s_axis_tready = (uw.op == spld_pkg::OP_WAIT);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = spld_pkg::DATA_BITS'(unsigned'(out_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= spld_pkg::ATTACK_RESET;
      release_q <= spld_pkg::RELEASE_RESET;
      mode_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        spld_pkg::CFG_ATTACK:  attack_q  <= cfg_data_i[CB-1:0];
        spld_pkg::CFG_RELEASE: release_q <= cfg_data_i[CB-1:0];
        spld_pkg::CFG_MODE:    mode_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    pc_d = pc_q + 1'b1;
    unique case (uw.jc)
      spld_pkg::JC_NEXT:    pc_d = pc_q + 1'b1;
      spld_pkg::JC_GOTO:    pc_d = uw.target;
      spld_pkg::JC_BEAT:    pc_d = !in_beat ? pc_q : (mode_q ? uw.target : pc_q + 1'b1);
      spld_pkg::JC_OUTFREE: pc_d = out_free ? uw.target : pc_q;
      default:              pc_d = spld_pkg::PC_WAIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= spld_pkg::PC_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

  // datapath
  assign xs    = TB'(signed'({sample_q, {GB{1'b0}}}));
  assign s_src = (uw.src == spld_pkg::SRC_PEAK) ? peak_q : smooth_q;
  assign x_src = (uw.inp == spld_pkg::INP_PEAK) ? peak_q : xs;
  assign diff  = DB'(s_src) - DB'(x_src);

  // round half up: +half for non-negative difference, +half-1 for negative
  assign rnd  = {1'b0, prod_q} + (PB + 1)'({1'b1, {(CB-1){1'b0}}}) - (PB + 1)'(neg_q);
  assign quot = rnd[PB:CB];
  assign acc  = neg_q ? QB'(xop_q) - quot : QB'(xop_q) + quot;
  assign res  = signed'(acc[TB-1:0]);

  assign lvl_sum = (TB + 1)'(smooth_q) + (TB + 1)'(1 << (GB - 1));
  assign lvl_sh  = lvl_sum[TB:GB];
  always_comb begin
    if (lvl_sh[SB] != lvl_sh[SB-1]) begin
      lvl = lvl_sh[SB] ? signed'({1'b1, {(SB-1){1'b0}}}) : signed'({1'b0, {(SB-1){1'b1}}});
    end else begin
      lvl = lvl_sh[SB-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      sample_q <= signed'(s_axis_tdata[SB-1:0]);
    end
    if (uw.op == spld_pkg::OP_LOAD) begin
      xop_q <= x_src;
      neg_q <= diff[DB-1];
      mag_q <= diff[DB-1] ? DB'(-diff) : DB'(diff);
      unique case (uw.coef)
        spld_pkg::COEF_ATTACK:  coef_q <= attack_q;
        spld_pkg::COEF_RELEASE: coef_q <= release_q;
        default:                coef_q <= (x_src < s_src) ? attack_q : release_q;
      endcase
    end
    if (uw.op == spld_pkg::OP_MUL) begin
      prod_q <= PB'(mag_q) * PB'(coef_q);
    end
    if (uw.op == spld_pkg::OP_EMIT && out_free) begin
      out_q <= lvl;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_q    <= '0;
      peak_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (uw.op == spld_pkg::OP_ACC) begin
        if (uw.dst == spld_pkg::DST_PEAK) begin
          peak_q <= (xop_q > res) ? xop_q : res;
        end else begin
          smooth_q <= res;
        end
      end
      if (uw.op == spld_pkg::OP_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= spld_pkg::PC_LAST)
    else $error("step counter beyond program");

  a_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> ((pc_q == spld_pkg::PC_DEC) == $past(mode_q))
             && ((pc_q == spld_pkg::PC_BR) == !$past(mode_q)))
    else $error("beat dispatched to wrong routine");

  a_valid_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(pc_q == spld_pkg::PC_EMIT))
    else $error("output beat raised outside emit step");

  a_no_beat_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q != spld_pkg::PC_WAIT) |-> !s_axis_tready)
    else $error("input taken during a pass");

endmodule

`default_nettype wire

/* tb/tb.sv */
`default_nettype none

module tb;

  localparam int unsigned PHASES_RND   = 10;
  localparam int unsigned ITEMS_RND    = 68;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned SETTLE       = 12;
  localparam logic [spld_pkg::CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;
  localparam logic MODE_BRANCHED  = 1'b0;
  localparam logic MODE_DECOUPLED = 1'b1;
  localparam logic [spld_pkg::SAMPLE_BITS-1:0] S_MAX = {1'b0, {(spld_pkg::SAMPLE_BITS-1){1'b1}}};
  localparam logic [spld_pkg::SAMPLE_BITS-1:0] S_MIN = {1'b1, {(spld_pkg::SAMPLE_BITS-1){1'b0}}};
  localparam logic [spld_pkg::COEFF_BITS-1:0]  C_MAX = '1;
  localparam longint LVL_MAX = (longint'(1) <<< (spld_pkg::SAMPLE_BITS - 1)) - 1;
  localparam longint LVL_MIN = -LVL_MAX - 1;
  localparam longint COEF_HALF = longint'(1) <<< (spld_pkg::COEFF_BITS - 1);
  localparam longint GUARD_HALF = longint'(1) <<< (spld_pkg::GUARD_BITS - 1);

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [spld_pkg::DATA_BITS-1:0] s_axis_tdata = '0;   // [23:0] sample
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [spld_pkg::DATA_BITS-1:0] m_axis_tdata;        // [23:0] level
  logic cfg_we_i = 1'b0;
  logic [spld_pkg::CFG_IDX_BITS-1:0] cfg_idx_i = '0;
  logic [spld_pkg::CFG_BITS-1:0] cfg_data_i = '0;

  smooth_peak_level_detector_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  logic [spld_pkg::SAMPLE_BITS-1:0] sample_q[$];
  logic [spld_pkg::SAMPLE_BITS-1:0] level_q[$];
  int unsigned smp_queued = 0;
  int unsigned smp_accepted = 0;
  int unsigned fails = 0;
  logic smp_taken = 1'b0;
  logic lvl_taken = 1'b0;
  logic idle_off = 1'b0;
  int unsigned hold_req = 0;

  // predictor copy of registers and state
  longint atk_alpha = longint'(spld_pkg::ATTACK_RESET);
  longint rel_alpha = longint'(spld_pkg::RELEASE_RESET);
  logic   det_mode  = MODE_BRANCHED;
  longint smooth_acc = 0;
  longint peak_acc = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic longint pole_filter(longint s, longint x, longint alpha);
    longint d;
    d = s - x;
    if (d >= 0) return x + ((d * alpha + COEF_HALF) >>> spld_pkg::COEFF_BITS);
    return x - (((-d) * alpha + COEF_HALF - 1) >>> spld_pkg::COEFF_BITS);
  endfunction

  function automatic logic [spld_pkg::SAMPLE_BITS-1:0] predict_level(
      logic [spld_pkg::SAMPLE_BITS-1:0] smp);
    longint x;
    longint rel;
    longint y;
    x = longint'($signed(smp)) * (longint'(1) <<< spld_pkg::GUARD_BITS);
    if (det_mode == MODE_BRANCHED) begin
      if (x < smooth_acc) smooth_acc = pole_filter(smooth_acc, x, atk_alpha);
      else smooth_acc = pole_filter(smooth_acc, x, rel_alpha);
    end else begin
      rel = pole_filter(peak_acc, x, rel_alpha);
      peak_acc = (x > rel) ? x : rel;
      smooth_acc = pole_filter(smooth_acc, peak_acc, atk_alpha);
    end
    y = (smooth_acc + GUARD_HALF) >>> spld_pkg::GUARD_BITS;
    if (y > LVL_MAX) y = LVL_MAX;
    if (y < LVL_MIN) y = LVL_MIN;
    return y[spld_pkg::SAMPLE_BITS-1:0];
  endfunction

  // sender
  int unsigned smp_wait = 0;
  always @(negedge clk_i) begin : drive_samples
    logic v;
    logic [spld_pkg::DATA_BITS-1:0] d;
    v = s_axis_tvalid;
    d = s_axis_tdata;
    if (rst_ni) begin
      if (smp_taken) v = 1'b0;
      if (!v) begin
        if (smp_wait > 0) begin
          smp_wait--;
        end else if (sample_q.size() != 0) begin
          d = '0;
          d[spld_pkg::SAMPLE_BITS-1:0] = sample_q.pop_front();
          v = 1'b1;
          smp_wait = idle_off ? 0 : $urandom_range(0, 9);
        end
      end
    end
    s_axis_tvalid <= v;
    s_axis_tdata <= d;
  end

  // receiver
  int unsigned lvl_wait = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  always @(negedge clk_i) begin : drive_ready
    logic r;
    r = 1'b0;
    if (rst_ni) begin
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
      end else begin
        if (lvl_taken) lvl_wait = idle_off ? 0 : $urandom_range(0, 9);
        if (lvl_wait > 0) lvl_wait--;
        else r = 1'b1;
      end
    end
    m_axis_tready <= r;
  end

  // monitor
  always @(posedge clk_i) begin : watch_beats
    logic [spld_pkg::SAMPLE_BITS-1:0] want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (level_q.size() == 0) begin
          $error("level: beat with nothing expected, actual %0d",
                 $signed(m_axis_tdata[spld_pkg::SAMPLE_BITS-1:0]));
          fails++;
        end else begin
          want = level_q.pop_front();
          if (m_axis_tdata[spld_pkg::SAMPLE_BITS-1:0] !== want) begin
            $error("level: expected %0d, actual %0d", $signed(want),
                   $signed(m_axis_tdata[spld_pkg::SAMPLE_BITS-1:0]));
            fails++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        level_q.push_back(predict_level(s_axis_tdata[spld_pkg::SAMPLE_BITS-1:0]));
        smp_accepted++;
      end
    end
    smp_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
    lvl_taken <= rst_ni && m_axis_tvalid && m_axis_tready;
  end

  task automatic set_reg(logic [spld_pkg::CFG_IDX_BITS-1:0] idx,
                         logic [spld_pkg::CFG_BITS-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      spld_pkg::CFG_ATTACK:  atk_alpha = longint'(val[spld_pkg::COEFF_BITS-1:0]);
      spld_pkg::CFG_RELEASE: rel_alpha = longint'(val[spld_pkg::COEFF_BITS-1:0]);
      spld_pkg::CFG_MODE:    det_mode = val[0];
      default:               ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic put_sample(logic [spld_pkg::SAMPLE_BITS-1:0] smp);
    sample_q.push_back(smp);
    smp_queued++;
  endtask

  task automatic drain();
    while (smp_accepted != smp_queued || level_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  function automatic logic [spld_pkg::COEFF_BITS-1:0] draw_coef();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return C_MAX;
      2:       return spld_pkg::COEFF_BITS'($urandom);
      default: return C_MAX - spld_pkg::COEFF_BITS'($urandom_range(0, 1 << 18));
    endcase
  endfunction

  initial begin
    logic [spld_pkg::SAMPLE_BITS-1:0] amp;
    logic [spld_pkg::SAMPLE_BITS-1:0] smp;
    int unsigned pick;
    amp = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // reset coefficients, branched
    put_sample(S_MAX);
    put_sample(S_MAX);
    put_sample(S_MIN);
    put_sample('0);
    put_sample(24'd1);
    put_sample('1);
    put_sample(S_MAX);
    put_sample(24'h400000);
    drain();

    // zero alpha: output follows input at once, both modes
    set_reg(spld_pkg::CFG_ATTACK, '0);
    set_reg(spld_pkg::CFG_RELEASE, '0);
    put_sample(S_MAX);
    put_sample(S_MIN);
    put_sample(24'd12345);
    put_sample('1);
    drain();
    set_reg(spld_pkg::CFG_MODE, spld_pkg::CFG_BITS'(MODE_DECOUPLED));
    put_sample(S_MIN);
    put_sample(S_MAX);
    put_sample('0);
    put_sample(24'h800001);
    drain();

    // full-scale alpha; mode write with high bits set; unused index ignored
    set_reg(spld_pkg::CFG_ATTACK, C_MAX);
    set_reg(spld_pkg::CFG_RELEASE, C_MAX);
    set_reg(spld_pkg::CFG_MODE, 24'hFFFFFE);
    set_reg(CFG_UNUSED, 24'h000001);
    put_sample(S_MAX);
    put_sample(S_MAX);
    put_sample(S_MIN);
    put_sample(S_MIN);
    put_sample(S_MAX);
    drain();

    // mode switching keeps both states
    set_reg(spld_pkg::CFG_ATTACK, 24'h800000);
    set_reg(spld_pkg::CFG_RELEASE, 24'hF40000);
    set_reg(spld_pkg::CFG_MODE, spld_pkg::CFG_BITS'(MODE_DECOUPLED));
    put_sample(S_MAX);
    put_sample('0);
    put_sample(S_MIN);
    drain();
    set_reg(spld_pkg::CFG_MODE, spld_pkg::CFG_BITS'(MODE_BRANCHED));
    put_sample(S_MIN);
    put_sample('0);
    drain();
    set_reg(spld_pkg::CFG_MODE, spld_pkg::CFG_BITS'(MODE_DECOUPLED));
    put_sample(24'd100);
    put_sample(24'hFFFFFB);
    drain();

    for (int p = 0; p < PHASES_RND; p++) begin
      set_reg(spld_pkg::CFG_ATTACK, draw_coef());
      set_reg(spld_pkg::CFG_RELEASE, draw_coef());
      set_reg(spld_pkg::CFG_MODE, spld_pkg::CFG_BITS'($urandom_range(0, 1)));
      idle_off = (p % 4 == 3) || (p == 2);
      if (p == 2) hold_req++;
      for (int i = 0; i < ITEMS_RND; i++) begin
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 15) == 0) begin
          case ($urandom_range(0, 2))
            0:       amp = spld_pkg::SAMPLE_BITS'($urandom_range(0, 32'(LVL_MAX)));
            1:       amp = spld_pkg::SAMPLE_BITS'($urandom_range(0, 4095));
            default: amp = S_MAX;
          endcase
        end
        if (pick < 60) smp = $urandom_range(0, 1) ? amp : -amp;
        else if (pick < 85) smp = spld_pkg::SAMPLE_BITS'($urandom);
        else if (pick < 92) smp = S_MAX;
        else smp = S_MIN;
        put_sample(smp);
      end
      drain();
    end

    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
